### hw/rtl/sct_pkg.sv
`timescale 1ns / 1ps

package sct_pkg;

    // Sample and confidence formats
    localparam int VALUE_BITS = 48;
    localparam int FRAC_BITS  = 16;
    localparam int CONF_W     = FRAC_BITS + 1;
    localparam int LIMIT_W    = VALUE_BITS - 1;
    localparam int TIME_W     = 32;
    localparam int CH_W       = 4;

    localparam logic [CONF_W-1:0] CONF_ONE = CONF_W'(1) << FRAC_BITS;

    // Channel map
    localparam int NUM_CH       = 11;
    localparam int NUM_VALUE_CH = 10;
    localparam int CONF_AW      = $clog2(NUM_CH);
    localparam int LAST_AW      = $clog2(NUM_VALUE_CH);

    localparam logic [CH_W-1:0] ACC_LAST_CH  = CH_W'(2);
    localparam logic [CH_W-1:0] ACC_Z_CH     = CH_W'(2);
    localparam logic [CH_W-1:0] GYRO_LAST_CH = CH_W'(5);
    localparam logic [CH_W-1:0] BARO_CH      = CH_W'(6);
    localparam logic [CH_W-1:0] GPS_CH       = CH_W'(10);

    // Last-value reset contents: gravity on acc z, sea-level pressure on baro
    localparam logic [VALUE_BITS-1:0] LAST_RST_ACC_Z =
        VALUE_BITS'((64'd981 << FRAC_BITS) / 100);
    localparam logic [VALUE_BITS-1:0] LAST_RST_BARO =
        VALUE_BITS'(64'd101325 << FRAC_BITS);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (LIMIT_W > TIME_W) ? LIMIT_W : TIME_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT    = 3'd0,
        REG_PENALTY    = 3'd1,
        REG_RECOVERY   = 3'd2,
        REG_SPIKE_ACC  = 3'd3,
        REG_SPIKE_GYRO = 3'd4,
        REG_SPIKE_BARO = 3'd5,
        REG_SPIKE_MAG  = 3'd6
    } cfg_reg_t;

    // Register reset values
    localparam logic [TIME_W-1:0]    TIMEOUT_RST  = TIME_W'(100000);
    localparam logic [FRAC_BITS-1:0] PENALTY_RST  = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [CONF_W-1:0]    RECOVERY_RST =
        CONF_W'(((64'd5 << FRAC_BITS) + 64'd50) / 100);
    localparam logic [LIMIT_W-1:0]   LIM_ACC_RST  = LIMIT_W'(64'd50 << FRAC_BITS);
    localparam logic [LIMIT_W-1:0]   LIM_GYRO_RST = LIMIT_W'(64'd10 << FRAC_BITS);
    localparam logic [LIMIT_W-1:0]   LIM_BARO_RST = LIMIT_W'(64'd500 << FRAC_BITS);
    localparam logic [LIMIT_W-1:0]   LIM_MAG_RST  = LIMIT_W'(64'd100 << FRAC_BITS);

    typedef struct packed {
        logic [TIME_W-1:0]    timeout;
        logic [FRAC_BITS-1:0] penalty;
        logic [CONF_W-1:0]    recovery;
        logic [LIMIT_W-1:0]   lim_acc;
        logic [LIMIT_W-1:0]   lim_gyro;
        logic [LIMIT_W-1:0]   lim_baro;
        logic [LIMIT_W-1:0]   lim_mag;
    } cfg_t;

    // Outcome of one read-modify-write
    typedef struct packed {
        logic [CONF_W-1:0] conf;
        logic              tmo;
        logic              spk;
        logic              conf_we;
        logic              last_we;
    } upd_t;

endpackage

### hw/rtl/sensor_confidence_tracker_top.sv
`timescale 1ns / 1ps

// Per-channel sensor confidence tracker. Takes one sample beat per cycle
// sustained while the output side is not stalled, for any mix of channels
// including the same channel repeated; each beat passes through the stage 1,
// stage 2 and output registers before its result beat is presented.
// Per-channel state sits in two small synchronous RAMs (confidence and last
// value); each sample does one read in the first stage and one write-back in
// the second, and the write of the sample just ahead is forwarded around the
// registered RAM read. Valid bits stand in for the reset contents, so the block
// is ready right after reset with no clearing pass. Configuration writes take
// effect on the next cycle and must only be issued while no sample is in flight.
module sensor_confidence_tracker_top
    import sct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CH_W-1:0]       s_channel,
    input  logic [VALUE_BITS-1:0] s_sample_value,
    input  logic [TIME_W-1:0]     s_sample_time,
    input  logic [TIME_W-1:0]     s_now_time,
    input  logic                  s_gps_fix,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_out_channel,
    output logic [CONF_W-1:0]     m_confidence,
    output logic                  m_timed_out,
    output logic                  m_spike_seen
);

    cfg_t cfg;

    // Pipeline control
    logic s_accept;
    logic p1_adv;
    logic p2_adv;

    // Stage 1: accepted sample, RAM read issued
    logic                  p1_valid_reg;
    logic [CH_W-1:0]       p1_ch_reg;
    logic [VALUE_BITS-1:0] p1_value_reg;
    logic [TIME_W-1:0]     p1_st_reg;
    logic [TIME_W-1:0]     p1_now_reg;
    logic                  p1_fix_reg;
    logic [TIME_W-1:0]     p1_age;
    logic                  p1_too_old;
    logic [LIMIT_W-1:0]    p1_limit;
    logic                  p1_conf_ch;
    logic                  p1_last_ch;

    // Stage 2: RAM data available, update and write back
    logic                  p2_valid_reg;
    logic [CH_W-1:0]       p2_ch_reg;
    logic [VALUE_BITS-1:0] p2_value_reg;
    logic                  p2_fix_reg;
    logic                  p2_too_old_reg;
    logic [LIMIT_W-1:0]    p2_limit_reg;
    logic                  p2_conf_vld_reg;
    logic                  p2_last_vld_reg;

    // Forwarding of the write that overlaps the read
    logic                  fwd_conf_hit_reg;
    logic                  fwd_conf_hit_next;
    logic [CONF_W-1:0]     fwd_conf_reg;
    logic                  fwd_last_hit_reg;
    logic                  fwd_last_hit_next;
    logic [VALUE_BITS-1:0] fwd_last_reg;

    // Entry valid bits
    logic [NUM_CH-1:0]       conf_vld_reg;
    logic [NUM_CH-1:0]       conf_vld_next;
    logic [NUM_VALUE_CH-1:0] last_vld_reg;
    logic [NUM_VALUE_CH-1:0] last_vld_next;

    // RAM ports
    logic [CONF_AW-1:0]    conf_raddr;
    logic [LAST_AW-1:0]    last_raddr;
    logic [CONF_W-1:0]     conf_rdata;
    logic [VALUE_BITS-1:0] last_rdata;
    logic                  conf_wr;
    logic                  last_wr;

    // Stage 2 operands
    logic [CONF_W-1:0]     conf_cur;
    logic [VALUE_BITS-1:0] last_rst;
    logic [VALUE_BITS-1:0] prev_cur;
    upd_t                  upd;

    // Output register
    logic                  m_valid_reg;
    logic [CH_W-1:0]       m_ch_reg;
    logic [CONF_W-1:0]     m_conf_reg;
    logic                  m_tmo_reg;
    logic                  m_spk_reg;

    sct_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake chain
    assign p2_adv   = p2_valid_reg && (!m_valid_reg || m_ready);
    assign p1_adv   = p1_valid_reg && (!p2_valid_reg || p2_adv);
    assign s_ready  = !p1_valid_reg || p1_adv;
    assign s_accept = s_valid && s_ready;

    // Stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_ch_reg    <= s_channel;
            p1_value_reg <= s_sample_value;
            p1_st_reg    <= s_sample_time;
            p1_now_reg   <= s_now_time;
            p1_fix_reg   <= s_gps_fix;
        end
    end

    // Sample age (wrapping) and class limit
    assign p1_age     = p1_now_reg - p1_st_reg;
    assign p1_too_old = p1_age > cfg.timeout;

    always_comb begin
        if (p1_ch_reg <= ACC_LAST_CH) begin
            p1_limit = cfg.lim_acc;
        end else if (p1_ch_reg <= GYRO_LAST_CH) begin
            p1_limit = cfg.lim_gyro;
        end else if (p1_ch_reg == BARO_CH) begin
            p1_limit = cfg.lim_baro;
        end else begin
            p1_limit = cfg.lim_mag;
        end
    end

    // Read addresses, parked at zero for channels without an entry
    assign p1_conf_ch = p1_ch_reg < CH_W'(NUM_CH);
    assign p1_last_ch = p1_ch_reg < CH_W'(NUM_VALUE_CH);
    assign conf_raddr = p1_conf_ch ? p1_ch_reg[CONF_AW-1:0] : '0;
    assign last_raddr = p1_last_ch ? p1_ch_reg[LAST_AW-1:0] : '0;

    // Write-back from stage 2
    assign conf_wr = p2_adv && upd.conf_we;
    assign last_wr = p2_adv && upd.last_we;

    sct_ram #(
        .WIDTH (CONF_W),
        .DEPTH (NUM_CH)
    ) u_conf_ram (
        .aclk  (aclk),
        .we    (conf_wr),
        .waddr (p2_ch_reg[CONF_AW-1:0]),
        .wdata (upd.conf),
        .re    (p1_adv),
        .raddr (conf_raddr),
        .rdata (conf_rdata)
    );

    sct_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NUM_VALUE_CH)
    ) u_last_ram (
        .aclk  (aclk),
        .we    (last_wr),
        .waddr (p2_ch_reg[LAST_AW-1:0]),
        .wdata (p2_value_reg),
        .re    (p1_adv),
        .raddr (last_raddr),
        .rdata (last_rdata)
    );

    // Valid bits set on first write
    always_comb begin
        conf_vld_next = conf_vld_reg;
        last_vld_next = last_vld_reg;
        if (conf_wr) begin
            conf_vld_next[p2_ch_reg[CONF_AW-1:0]] = 1'b1;
        end
        if (last_wr) begin
            last_vld_next[p2_ch_reg[LAST_AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conf_vld_reg <= '0;
            last_vld_reg <= '0;
        end else begin
            conf_vld_reg <= conf_vld_next;
            last_vld_reg <= last_vld_next;
        end
    end

    // Same-entry write in the read cycle is forwarded
    assign fwd_conf_hit_next = conf_wr && (p2_ch_reg == p1_ch_reg);
    assign fwd_last_hit_next = last_wr && (p2_ch_reg == p1_ch_reg);

    // Stage 2 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            p2_valid_reg <= 1'b1;
        end else if (p2_adv) begin
            p2_valid_reg <= 1'b0;
        end
    end

    // Stage 2 payload
    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            p2_ch_reg        <= p1_ch_reg;
            p2_value_reg     <= p1_value_reg;
            p2_fix_reg       <= p1_fix_reg;
            p2_too_old_reg   <= p1_too_old;
            p2_limit_reg     <= p1_limit;
            p2_conf_vld_reg  <= p1_conf_ch && conf_vld_reg[conf_raddr];
            p2_last_vld_reg  <= p1_last_ch && last_vld_reg[last_raddr];
            fwd_conf_hit_reg <= fwd_conf_hit_next;
            fwd_conf_reg     <= upd.conf;
            fwd_last_hit_reg <= fwd_last_hit_next;
            fwd_last_reg     <= p2_value_reg;
        end
    end

    // Reset contents of the last-value store
    always_comb begin
        if (p2_ch_reg == ACC_Z_CH) begin
            last_rst = LAST_RST_ACC_Z;
        end else if (p2_ch_reg == BARO_CH) begin
            last_rst = LAST_RST_BARO;
        end else begin
            last_rst = '0;
        end
    end

    // Current state: forwarded, stored or reset value
    assign conf_cur = fwd_conf_hit_reg ? fwd_conf_reg :
                      p2_conf_vld_reg  ? conf_rdata   : '0;
    assign prev_cur = fwd_last_hit_reg ? fwd_last_reg :
                      p2_last_vld_reg  ? last_rdata   : last_rst;

    sct_update u_update (
        .ch       (p2_ch_reg),
        .too_old  (p2_too_old_reg),
        .gps_fix  (p2_fix_reg),
        .cur      (p2_value_reg),
        .prev     (prev_cur),
        .conf     (conf_cur),
        .limit    (p2_limit_reg),
        .penalty  (cfg.penalty),
        .recovery (cfg.recovery),
        .upd      (upd)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p2_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_adv) begin
            m_ch_reg   <= p2_ch_reg;
            m_conf_reg <= upd.conf;
            m_tmo_reg  <= upd.tmo;
            m_spk_reg  <= upd.spk;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_ch_reg;
    assign m_confidence  = m_conf_reg;
    assign m_timed_out   = m_tmo_reg;
    assign m_spike_seen  = m_spk_reg;

endmodule

### hw/rtl/sct_ram.sv
`timescale 1ns / 1ps

module sct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/sct_cfg_regs.sv
`timescale 1ns / 1ps

module sct_cfg_regs
    import sct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_TIMEOUT:    cfg_next.timeout  = cfg_wdata[TIME_W-1:0];
                REG_PENALTY:    cfg_next.penalty  = cfg_wdata[FRAC_BITS-1:0];
                REG_RECOVERY:   cfg_next.recovery = cfg_wdata[CONF_W-1:0];
                REG_SPIKE_ACC:  cfg_next.lim_acc  = cfg_wdata[LIMIT_W-1:0];
                REG_SPIKE_GYRO: cfg_next.lim_gyro = cfg_wdata[LIMIT_W-1:0];
                REG_SPIKE_BARO: cfg_next.lim_baro = cfg_wdata[LIMIT_W-1:0];
                REG_SPIKE_MAG:  cfg_next.lim_mag  = cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout  <= TIMEOUT_RST;
            cfg_reg.penalty  <= PENALTY_RST;
            cfg_reg.recovery <= RECOVERY_RST;
            cfg_reg.lim_acc  <= LIM_ACC_RST;
            cfg_reg.lim_gyro <= LIM_GYRO_RST;
            cfg_reg.lim_baro <= LIM_BARO_RST;
            cfg_reg.lim_mag  <= LIM_MAG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/sct_update.sv
`timescale 1ns / 1ps

module sct_update
    import sct_pkg::*;
(
    input  logic [CH_W-1:0]       ch,
    input  logic                  too_old,
    input  logic                  gps_fix,
    input  logic [VALUE_BITS-1:0] cur,
    input  logic [VALUE_BITS-1:0] prev,
    input  logic [CONF_W-1:0]     conf,
    input  logic [LIMIT_W-1:0]    limit,
    input  logic [FRAC_BITS-1:0]  penalty,
    input  logic [CONF_W-1:0]     recovery,
    output upd_t                  upd
);

    logic [VALUE_BITS:0]           cur_ext;
    logic [VALUE_BITS:0]           prev_ext;
    logic [VALUE_BITS:0]           diff_pos;
    logic [VALUE_BITS:0]           diff_neg;
    logic [VALUE_BITS:0]           jump;
    logic                          spike;
    logic [CONF_W+FRAC_BITS-1:0]   prod;
    logic [CONF_W-1:0]             penalized;
    logic [CONF_W:0]               sum;
    logic [CONF_W-1:0]             recovered;

    // Absolute jump: both differences in parallel, pick by sign
    assign cur_ext  = {cur[VALUE_BITS-1], cur};
    assign prev_ext = {prev[VALUE_BITS-1], prev};
    assign diff_pos = cur_ext - prev_ext;
    assign diff_neg = prev_ext - cur_ext;
    assign jump     = diff_pos[VALUE_BITS] ? diff_neg : diff_pos;
    assign spike    = jump > {2'b00, limit};

    // Spike penalty, truncating
    assign prod      = conf * penalty;
    assign penalized = prod[FRAC_BITS +: CONF_W];

    // Recovery, saturating at 1.0
    assign sum       = {1'b0, conf} + {1'b0, recovery};
    assign recovered = (sum > {1'b0, CONF_ONE}) ? CONF_ONE : sum[CONF_W-1:0];

    always_comb begin
        upd = '0;
        if (ch == GPS_CH) begin
            upd.conf_we = 1'b1;
            if (too_old || !gps_fix) begin
                upd.tmo = 1'b1;
            end else begin
                upd.conf = recovered;
            end
        end else if (ch < CH_W'(NUM_VALUE_CH)) begin
            upd.conf_we = 1'b1;
            if (too_old) begin
                upd.tmo = 1'b1;
            end else if (spike) begin
                upd.spk  = 1'b1;
                upd.conf = penalized;
            end else begin
                upd.conf    = recovered;
                upd.last_we = 1'b1;
            end
        end
    end

endmodule

### tb/sv/sct_confidence_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both channels, keeps its own copy of the
// per-channel state and compares every result beat with the oldest prediction.
module sct_confidence_checker
    import sct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [CH_W-1:0]       s_channel,
    input  logic [VALUE_BITS-1:0] s_sample_value,
    input  logic [TIME_W-1:0]     s_sample_time,
    input  logic [TIME_W-1:0]     s_now_time,
    input  logic                  s_gps_fix,

    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [CH_W-1:0]       m_out_channel,
    input  logic [CONF_W-1:0]     m_confidence,
    input  logic                  m_timed_out,
    input  logic                  m_spike_seen,

    output int                    mismatch_count,
    output int                    pending_count
);

    localparam int FULL_CONF  = 65536;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [CONF_W-1:0] conf;
        logic              timed_out;
        logic              spike;
    } conf_beat_t;

    conf_beat_t expected_conf_q[$];
    int         beat_count;

    // Shadow registers
    logic [TIME_W-1:0]    timeout_lim;
    logic [FRAC_BITS-1:0] penalty;
    logic [CONF_W-1:0]    recovery;
    logic [LIMIT_W-1:0]   lim_acc;
    logic [LIMIT_W-1:0]   lim_gyro;
    logic [LIMIT_W-1:0]   lim_baro;
    logic [LIMIT_W-1:0]   lim_mag;

    // Shadow per-channel state
    logic [VALUE_BITS-1:0] shadow_last [NUM_VALUE_CH];
    logic [CONF_W-1:0]     conf_mem [NUM_CH];

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    function automatic void clear_state();
        timeout_lim = 32'd100000;
        penalty     = 16'd32768;
        recovery    = 17'd3277;
        lim_acc     = 47'd3276800;
        lim_gyro    = 47'd655360;
        lim_baro    = 47'd32768000;
        lim_mag     = 47'd6553600;
        for (int i = 0; i < NUM_VALUE_CH; i++) begin
            shadow_last[i] = '0;
        end
        // gravity on acc z, sea-level pressure on baro
        shadow_last[2] = 48'd642908;
        shadow_last[6] = 48'd6640435200;
        for (int i = 0; i < NUM_CH; i++) begin
            conf_mem[i] = '0;
        end
    endfunction

    function automatic void write_shadow(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TIMEOUT:    timeout_lim = data[TIME_W-1:0];
            REG_PENALTY:    penalty     = data[FRAC_BITS-1:0];
            REG_RECOVERY:   recovery    = data[CONF_W-1:0];
            REG_SPIKE_ACC:  lim_acc     = data[LIMIT_W-1:0];
            REG_SPIKE_GYRO: lim_gyro    = data[LIMIT_W-1:0];
            REG_SPIKE_BARO: lim_baro    = data[LIMIT_W-1:0];
            REG_SPIKE_MAG:  lim_mag     = data[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] class_limit(input logic [CH_W-1:0] ch);
        if (ch <= ACC_LAST_CH) return lim_acc;
        else if (ch <= GYRO_LAST_CH) return lim_gyro;
        else if (ch == BARO_CH) return lim_baro;
        return lim_mag;
    endfunction

    // Saturating add of the recovery step
    function automatic logic [CONF_W-1:0] recovered(input logic [CONF_W-1:0] c);
        logic [CONF_W:0] sum;
        sum = {1'b0, c} + {1'b0, recovery};
        return (sum > FULL_CONF) ? CONF_W'(FULL_CONF) : sum[CONF_W-1:0];
    endfunction

    // One read-modify-write of the shadow state; returns the result beat
    function automatic conf_beat_t next_confidence(input logic [CH_W-1:0] ch,
                                                   input logic [VALUE_BITS-1:0] val,
                                                   input logic [TIME_W-1:0] st,
                                                   input logic [TIME_W-1:0] now,
                                                   input logic fix);
        logic [TIME_W-1:0]               age;
        logic                            too_old;
        logic signed [VALUE_BITS:0]      jump;
        logic [VALUE_BITS:0]             jump_mag;
        logic [VALUE_BITS:0]             lim_ext;
        logic [CONF_W+FRAC_BITS-1:0]     product;
        conf_beat_t                      r;
        r.channel   = ch;
        r.conf      = '0;
        r.timed_out = 1'b0;
        r.spike     = 1'b0;
        age     = now - st;
        too_old = age > timeout_lim;
        if (ch == GPS_CH) begin
            if (too_old || !fix) begin
                conf_mem[ch] = '0;
                r.timed_out  = 1'b1;
            end else begin
                conf_mem[ch] = recovered(conf_mem[ch]);
            end
            r.conf = conf_mem[ch];
        end else if (ch < CH_W'(NUM_VALUE_CH)) begin
            if (too_old) begin
                conf_mem[ch] = '0;
                r.timed_out  = 1'b1;
            end else begin
                jump = $signed({val[VALUE_BITS-1], val})
                     - $signed({shadow_last[ch][VALUE_BITS-1], shadow_last[ch]});
                jump_mag = jump[VALUE_BITS] ? -jump : jump;
                lim_ext  = {2'b00, class_limit(ch)};
                if (jump_mag > lim_ext) begin
                    r.spike      = 1'b1;
                    product      = conf_mem[ch] * penalty;
                    conf_mem[ch] = product[CONF_W+FRAC_BITS-1:FRAC_BITS];
                end else begin
                    conf_mem[ch]    = recovered(conf_mem[ch]);
                    shadow_last[ch] = val;
                end
            end
            r.conf = conf_mem[ch];
        end
        return r;
    endfunction

    always @(posedge aclk) begin : track
        conf_beat_t want;
        if (!aresetn) begin
            clear_state();
            expected_conf_q.delete();
            mismatch_count = 0;
            beat_count     = 0;
        end else begin
            // result side first: a beat can never belong to a sample of this edge
            if (m_valid && m_ready) begin
                if (expected_conf_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "result beat %0d on channel %0d with none expected",
                        beat_count, m_out_channel));
                end else begin
                    want = expected_conf_q.pop_front();
                    if (m_out_channel !== want.channel || m_confidence !== want.conf ||
                        m_timed_out !== want.timed_out || m_spike_seen !== want.spike) begin
                        report_mismatch({
                            $sformatf("beat %0d got ch=%0d conf=%0d tmo=%b spk=%b, ",
                                      beat_count, m_out_channel, m_confidence,
                                      m_timed_out, m_spike_seen),
                            $sformatf("want ch=%0d conf=%0d tmo=%b spk=%b",
                                      want.channel, want.conf, want.timed_out,
                                      want.spike)});
                    end
                end
                beat_count++;
            end
            if (cfg_we) begin
                write_shadow(cfg_index, cfg_wdata);
            end
            if (s_valid && s_ready) begin
                expected_conf_q.push_back(next_confidence(s_channel, s_sample_value,
                                                          s_sample_time, s_now_time, s_gps_fix));
            end
        end
        pending_count <= expected_conf_q.size();
    end

endmodule

### tb/sv/sensor_confidence_tracker_top_tb.sv
`timescale 1ns / 1ps

module sensor_confidence_tracker_top_tb;
    import sct_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 200;
    localparam int NUM_PHASES   = 5;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [LIMIT_W-1:0]   LIMIT_MAX = '1;
    localparam logic [VALUE_BITS-1:0] VAL_MAX  = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VAL_MIN  = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [CH_W-1:0]       s_channel      = '0;
    logic [VALUE_BITS-1:0] s_sample_value = '0;
    logic [TIME_W-1:0]     s_sample_time  = '0;
    logic [TIME_W-1:0]     s_now_time     = '0;
    logic                  s_gps_fix      = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [CH_W-1:0]       m_out_channel;
    logic [CONF_W-1:0]     m_confidence;
    logic                  m_timed_out;
    logic                  m_spike_seen;

    int mismatch_count;
    int pending_count;
    int sent_count   = 0;
    int cycle_count  = 0;
    bit quiet_run    = 1'b0;
    bit hold_done    = 1'b0;

    // register copy used only to aim the random samples
    logic [TIME_W-1:0]     aim_timeout;
    logic [LIMIT_W-1:0]    aim_lim [4];
    logic [VALUE_BITS-1:0] near_val [NUM_VALUE_CH];

    sensor_confidence_tracker_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel      (s_channel),
        .s_sample_value (s_sample_value),
        .s_sample_time  (s_sample_time),
        .s_now_time     (s_now_time),
        .s_gps_fix      (s_gps_fix),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_channel  (m_out_channel),
        .m_confidence   (m_confidence),
        .m_timed_out    (m_timed_out),
        .m_spike_seen   (m_spike_seen)
    );

    sct_confidence_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel      (s_channel),
        .s_sample_value (s_sample_value),
        .s_sample_time  (s_sample_time),
        .s_now_time     (s_now_time),
        .s_gps_fix      (s_gps_fix),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_channel  (m_out_channel),
        .m_confidence   (m_confidence),
        .m_timed_out    (m_timed_out),
        .m_spike_seen   (m_spike_seen),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("sensor_confidence_tracker_top test failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, a few long ones, none in a quiet run
    function automatic int pick_gap();
        int r;
        if (quiet_run) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int class_of(input logic [CH_W-1:0] ch);
        if (ch <= ACC_LAST_CH) return 0;
        if (ch <= GYRO_LAST_CH) return 1;
        if (ch == BARO_CH) return 2;
        return 3;
    endfunction

    // Result side: random stalls plus one long hold-off while samples keep coming
    initial begin : result_sink
        int gap;
        forever begin
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                m_ready   = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(negedge aclk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [VALUE_BITS-1:0] val,
                               input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] now,
                               input logic fix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_channel      = ch;
        s_sample_value = val;
        s_sample_time  = st;
        s_now_time     = now;
        s_gps_fix      = fix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_TIMEOUT:    aim_timeout = data[TIME_W-1:0];
            REG_SPIKE_ACC:  aim_lim[0]  = data[LIMIT_W-1:0];
            REG_SPIKE_GYRO: aim_lim[1]  = data[LIMIT_W-1:0];
            REG_SPIKE_BARO: aim_lim[2]  = data[LIMIT_W-1:0];
            REG_SPIKE_MAG:  aim_lim[3]  = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [LIMIT_W-1:0] rand_limit();
        return LIMIT_W'({32'b0, $urandom} << $urandom_range(0, 15));
    endfunction

    task automatic configure(input int phase);
        case (phase)
            1: begin
                // everything at its top end
                write_reg(REG_TIMEOUT, '1);
                write_reg(REG_PENALTY, CFG_DATA_W'(16'hFFFF));
                write_reg(REG_RECOVERY, CFG_DATA_W'(17'd65536));
                write_reg(REG_SPIKE_ACC, LIMIT_MAX);
                write_reg(REG_SPIKE_GYRO, LIMIT_MAX);
                write_reg(REG_SPIKE_BARO, LIMIT_MAX);
                write_reg(REG_SPIKE_MAG, LIMIT_MAX);
            end
            2: begin
                write_reg(REG_TIMEOUT, '0);
                write_reg(REG_PENALTY, '0);
                write_reg(REG_RECOVERY, '0);
                write_reg(REG_SPIKE_ACC, '0);
                write_reg(REG_SPIKE_GYRO, '0);
                write_reg(REG_SPIKE_BARO, '0);
                write_reg(REG_SPIKE_MAG, '0);
            end
            3: begin
                write_reg(REG_TIMEOUT, CFG_DATA_W'($urandom_range(10, 300000)));
                write_reg(REG_PENALTY, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_RECOVERY, CFG_DATA_W'($urandom_range(0, 65536)));
                write_reg(REG_SPIKE_ACC, rand_limit());
                write_reg(REG_SPIKE_GYRO, rand_limit());
                write_reg(REG_SPIKE_BARO, rand_limit());
                write_reg(REG_SPIKE_MAG, rand_limit());
                write_reg(REG_SPARE, CFG_DATA_W'(rand64()));
            end
            default: begin
                // recovery step wider than 1.0 still saturates
                write_reg(REG_SPARE, '0);
                write_reg(REG_TIMEOUT, CFG_DATA_W'(32'd1000));
                write_reg(REG_PENALTY, CFG_DATA_W'(16'd49152));
                write_reg(REG_RECOVERY, CFG_DATA_W'(17'h1FFFF));
                write_reg(REG_SPIKE_ACC, rand_limit());
                write_reg(REG_SPIKE_MAG, rand_limit());
            end
        endcase
    endtask

    // Mostly in-window ages and small jumps, with boundaries and noise mixed in
    task automatic send_random();
        logic [CH_W-1:0]       ch;
        logic [VALUE_BITS-1:0] val;
        logic [VALUE_BITS-1:0] near;
        logic [TIME_W-1:0]     now;
        logic [TIME_W-1:0]     age;
        logic [63:0]           lim;
        logic [63:0]           off;
        logic                  fix;
        bit                    healthy;
        int                    r;
        if ($urandom_range(0, 19) == 0) ch = CH_W'($urandom_range(NUM_CH, 15));
        else ch = CH_W'($urandom_range(0, NUM_CH - 1));
        now = $urandom;
        fix = ($urandom_range(0, 7) != 0);

        r = $urandom_range(0, 99);
        if (r < 60) age = TIME_W'({32'b0, $urandom} % ({32'b0, aim_timeout} + 64'd1));
        else if (r < 70) age = aim_timeout;
        else if (r < 78) age = '0;
        else if (r < 88) age = aim_timeout + 1;
        else age = $urandom;

        near    = (ch < CH_W'(NUM_VALUE_CH)) ? near_val[ch] : '0;
        lim     = {{(64-LIMIT_W){1'b0}}, aim_lim[class_of(ch)]};
        healthy = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            off = rand64() % (lim + 64'd1);
            val = $urandom_range(0, 1) ? near - off[VALUE_BITS-1:0]
                                       : near + off[VALUE_BITS-1:0];
            healthy = 1'b1;
        end else if (r < 76) begin
            val     = near + lim[VALUE_BITS-1:0];
            healthy = 1'b1;
        end else if (r < 82) begin
            val = near - lim[VALUE_BITS-1:0] - VALUE_BITS'(1);
        end else if (r < 90) begin
            val = VALUE_BITS'(rand64());
        end else if (r < 95) begin
            val = VAL_MAX;
        end else begin
            val = VAL_MIN;
        end

        if (healthy && ch < CH_W'(NUM_VALUE_CH) && age <= aim_timeout) near_val[ch] = val;
        send_sample(ch, val, now - age, now, fix);
    endtask

    // Stimulus
    initial begin : stimulus
        int n_items;
        aim_timeout = 32'd100000;
        aim_lim[0]  = 47'd3276800;
        aim_lim[1]  = 47'd655360;
        aim_lim[2]  = 47'd32768000;
        aim_lim[3]  = 47'd6553600;
        for (int i = 0; i < NUM_VALUE_CH; i++) begin
            near_val[i] = '0;
        end
        near_val[2] = 48'd642908;
        near_val[6] = 48'd6640435200;

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed samples at the reset register values
        send_sample(4'd0, 48'd0, 32'd1000, 32'd1000, 1'b0);
        send_sample(4'd0, 48'd3276800, 32'd1000, 32'd1000, 1'b0);   // jump equal to limit
        send_sample(4'd0, '1, 32'd1000, 32'd1000, 1'b1);            // one past limit: spike
        send_sample(4'd2, 48'd642908 + 48'd3276800, '0, '0, 1'b0);  // from gravity
        send_sample(4'd6, 48'd6640435200 + 48'd32768001, 32'd7, 32'd7, 1'b0);
        send_sample(4'd6, 48'd6640435200, 32'd7, 32'd7, 1'b0);
        send_sample(4'd3, 48'd655360, 32'd50, 32'd60, 1'b0);
        send_sample(4'd7, VAL_MAX, 32'd0, 32'd0, 1'b0);
        send_sample(4'd8, VAL_MIN, 32'd0, 32'd0, 1'b0);
        send_sample(4'd9, 48'd6553600, 32'd0, 32'd99999, 1'b0);
        send_sample(4'd1, 48'd0, 32'd0, 32'd100000, 1'b0);          // age equal to timeout
        send_sample(4'd1, 48'd0, 32'd0, 32'd100001, 1'b0);          // one past timeout
        send_sample(4'd4, 48'd0, 32'hFFFF_FFF0, 32'd5, 1'b0);       // wrapped age
        send_sample(4'd5, 48'd0, 32'd1, 32'd0, 1'b0);               // age wraps to max
        send_sample(GPS_CH, 48'd0, 32'd10, 32'd10, 1'b1);
        send_sample(GPS_CH, VAL_MAX, 32'd10, 32'd20, 1'b1);
        send_sample(GPS_CH, 48'd0, 32'd10, 32'd20, 1'b0);           // no fix
        send_sample(GPS_CH, 48'd0, 32'd0, 32'd200000, 1'b1);        // stale fix
        send_sample(GPS_CH, VAL_MIN, '1, '1, 1'b1);
        send_sample(4'd11, VAL_MAX, '1, '1, 1'b1);                  // unused channel
        send_sample(4'd15, '1, 32'd0, 32'd0, 1'b1);
        send_sample(4'd0, 48'd3276800, 32'd3, 32'd3, 1'b1);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                configure(phase);
            end
            n_items = (phase == 0 || phase == 3) ? 90 : 70;
            for (int i = 0; i < n_items; i++) begin
                if (i % 32 == 0) quiet_run = ($urandom_range(0, 3) == 0);
                send_random();
            end
        end
        quiet_run = 1'b0;

        // drain and give the verdict
        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("sensor_confidence_tracker_top test passed");
        end else begin
            $display("sensor_confidence_tracker_top test failed");
        end
        $finish;
    end

endmodule
